### hw/rtl/siamp_pkg.sv
// ----------------------------------------------------------------------------
// siamp_pkg: shared definitions for the signed integer alu
// Operation codes, status codes, sequencer states and the default word width.
// ----------------------------------------------------------------------------
package siamp_pkg;

  // default datapath width
  localparam int WORD_BITS_DEF = 64;

  // operation codes
  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_SUB    = 3'd1;
  localparam logic [2:0] FN_MUL    = 3'd2;
  localparam logic [2:0] FN_DIV    = 3'd3;
  localparam logic [2:0] FN_POW    = 3'd4;
  localparam logic [2:0] FN_MODPOW = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_OVF    = 2'd1;
  localparam logic [1:0] STAT_NEGEXP = 2'd2;
  localparam logic [1:0] STAT_ZMOD   = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MFIN,
    S_RED,
    S_RFIN,
    S_DIV,
    S_DFIN,
    S_STEP,
    S_SQ
  } state_t;

  // destination of a power-loop product
  typedef enum logic {
    DST_T,
    DST_B
  } dest_t;

endpackage

### hw/rtl/signed_int_alu_muldiv_powmod.sv
// ----------------------------------------------------------------------------
// signed_int_alu_muldiv_powmod: iterative two's complement alu
// Add, subtract, multiply, divide, power and modular power on one shared
// adder-subtractor stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: drive in_func and the three operands and raise start; the beat is
// taken at a rising edge with start high and busy low. busy stays high while
// an operation runs. The answer appears on out_result, out_remainder and
// out_status for exactly one cycle with out_valid high; the receiver cannot
// stall, so it must capture the beat in that cycle.
// One adder serves the multiply loop, the division loop and the double width
// reduction loop, at one multiplier, quotient or reduction bit a cycle. Add,
// sub, unused codes, division by zero and flagged pow/modpow are answered
// straight from idle without entering a loop. Items are handled one at a
// time; a new beat may be taken in the cycle its predecessor's result is
// shown. Synchronous reset returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module signed_int_alu_muldiv_powmod
  import siamp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  input  logic signed [63:0] in_modulus,
  output logic               out_valid,
  output logic signed [63:0] out_result,
  output logic signed [63:0] out_remainder,
  output logic [1:0]         out_status
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(2 * W);
  localparam logic [W-1:0] SIGN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_W  = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] ZERO_W = {W{1'b0}};

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] x);
    return x[W-1] ? (ZERO_W - x) : x;
  endfunction

  function automatic logic [63:0] sx_f(input logic [W-1:0] x);
    return 64'($signed(x));
  endfunction

  state_t state_r, state_nxt;
  dest_t  dest_r, dest_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [2*W-1:0] p_r, p_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  mx_r, mx_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  t_r, t_nxt;
  logic [W-1:0]  base_r, base_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          asgn_r, asgn_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ov_r, ov_nxt;
  logic [63:0]   ores_r, ores_nxt;
  logic [63:0]   orem_r, orem_nxt;
  logic [1:0]    ost_r, ost_nxt;

  logic [W-1:0] a_w, b_w, c_w;
  logic [W:0]   au_a, au_b;
  logic         au_sub;
  logic [W+1:0] au_sum;
  logic         borrow;
  logic         accept;

  logic         m_zero, m_neg, m_ovf;
  logic [W-1:0] m_lo, m_val, r_val, q_val;

  assign a_w = in_operand_a[W-1:0];
  assign b_w = in_operand_b[W-1:0];
  assign c_w = in_modulus[W-1:0];
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // shared adder-subtractor
  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b0;
    case (state_r)
      S_IDLE: begin
        au_a   = {1'b0, a_w};
        au_b   = {1'b0, b_w};
        au_sub = (in_func == FN_SUB);
      end
      S_MUL: begin
        au_a = {1'b0, p_r[2*W-1:W]};
        au_b = p_r[0] ? {1'b0, mx_r} : '0;
      end
      S_RED: begin
        au_a   = {r_r, p_r[2*W-1]};
        au_b   = {1'b0, m_r};
        au_sub = 1'b1;
      end
      S_DIV: begin
        au_a   = {r_r, p_r[W-1]};
        au_b   = {1'b0, m_r};
        au_sub = 1'b1;
      end
      default: begin
        au_a = '0;
      end
    endcase
  end

  assign au_sum = {1'b0, au_a} + ({1'b0, au_b} ^ {(W+2){au_sub}})
                + {{(W+1){1'b0}}, au_sub};
  assign borrow = au_sum[W+1];

  // finishing of products, reductions and quotients
  always_comb begin
    m_lo  = p_r[W-1:0];
    m_zero = (p_r == '0);
    m_neg = neg_r && !m_zero;
    m_ovf = (p_r[2*W-1:W] != ZERO_W) || (m_lo > (m_neg ? SIGN_W : SIGN_W - ONE_W));
    m_val = m_neg ? (ZERO_W - m_lo) : m_lo;
    r_val = neg_r ? (ZERO_W - r_r) : r_r;
    q_val = neg_r ? (ZERO_W - p_r[W-1:0]) : p_r[W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_MUL: state_nxt = S_MUL;
            FN_DIV: if (b_w != ZERO_W) state_nxt = S_DIV;
            FN_POW: if (!b_w[W-1]) state_nxt = S_STEP;
            FN_MODPOW: if (!b_w[W-1] && c_w != ZERO_W) state_nxt = S_STEP;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: if (cnt_r == '0) state_nxt = S_MFIN;
      S_MFIN: begin
        if (func_r == FN_MUL) state_nxt = S_IDLE;
        else if (func_r == FN_MODPOW) state_nxt = S_RED;
        else state_nxt = (dest_r == DST_T) ? S_SQ : S_STEP;
      end
      S_RED: if (cnt_r == '0) state_nxt = S_RFIN;
      S_RFIN: state_nxt = (dest_r == DST_T) ? S_SQ : S_STEP;
      S_DIV: if (cnt_r == '0) state_nxt = S_DFIN;
      S_DFIN: state_nxt = S_IDLE;
      S_STEP: begin
        if (e_r == ZERO_W) state_nxt = S_IDLE;
        else if (e_r[0]) state_nxt = S_MUL;
        else state_nxt = S_SQ;
      end
      S_SQ: state_nxt = (e_r[W-1:1] != '0) ? S_MUL : S_STEP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    dest_nxt = dest_r;
    func_nxt = func_r;
    p_nxt    = p_r;
    r_nxt    = r_r;
    mx_nxt   = mx_r;
    m_nxt    = m_r;
    t_nxt    = t_r;
    base_nxt = base_r;
    e_nxt    = e_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    asgn_nxt = asgn_r;
    ovf_nxt  = ovf_r;
    ov_nxt   = 1'b0;
    ores_nxt = ores_r;
    orem_nxt = orem_r;
    ost_nxt  = ost_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = in_func;
          ovf_nxt  = 1'b0;
          case (in_func)
            FN_ADD, FN_SUB: begin
              ov_nxt   = 1'b1;
              ores_nxt = sx_f(au_sum[W-1:0]);
              orem_nxt = '0;
              ost_nxt  = (a_w[W-1] == ((in_func == FN_ADD) ? b_w[W-1] : !b_w[W-1])
                          && au_sum[W-1] != a_w[W-1]) ? STAT_OVF : STAT_OK;
            end
            FN_MUL: begin
              p_nxt   = {ZERO_W, mag_f(b_w)};
              mx_nxt  = mag_f(a_w);
              neg_nxt = a_w[W-1] ^ b_w[W-1];
              cnt_nxt = CW'(W - 1);
            end
            FN_DIV: begin
              if (b_w == ZERO_W) begin
                ov_nxt   = 1'b1;
                ores_nxt = sx_f(a_w[W-1] ? SIGN_W : SIGN_W - ONE_W);
                orem_nxt = sx_f(a_w);
                ost_nxt  = STAT_OVF;
              end else begin
                p_nxt    = {ZERO_W, mag_f(a_w)};
                r_nxt    = ZERO_W;
                m_nxt    = mag_f(b_w);
                neg_nxt  = a_w[W-1] ^ b_w[W-1];
                asgn_nxt = a_w[W-1];
                cnt_nxt  = CW'(W - 1);
              end
            end
            FN_POW, FN_MODPOW: begin
              if (b_w[W-1] || (in_func == FN_MODPOW && c_w == ZERO_W)) begin
                ov_nxt   = 1'b1;
                ores_nxt = '0;
                orem_nxt = '0;
                ost_nxt  = b_w[W-1] ? STAT_NEGEXP : STAT_ZMOD;
              end else begin
                base_nxt = a_w;
                e_nxt    = b_w;
                m_nxt    = mag_f(c_w);
                t_nxt    = (in_func == FN_MODPOW && mag_f(c_w) == ONE_W) ? ZERO_W : ONE_W;
              end
            end
            default: begin
              ov_nxt   = 1'b1;
              ores_nxt = '0;
              orem_nxt = '0;
              ost_nxt  = STAT_OK;
            end
          endcase
        end
      end
      // shift-add multiply, one multiplier bit a cycle
      S_MUL: begin
        p_nxt   = {au_sum[W:0], p_r[W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
      end
      S_MFIN: begin
        if (func_r == FN_MUL) begin
          ov_nxt   = 1'b1;
          ores_nxt = sx_f(m_val);
          orem_nxt = '0;
          ost_nxt  = m_ovf ? STAT_OVF : STAT_OK;
        end else if (func_r == FN_MODPOW) begin
          r_nxt   = ZERO_W;
          cnt_nxt = CW'(2 * W - 1);
        end else begin
          ovf_nxt = ovf_r | m_ovf;
          if (dest_r == DST_T) t_nxt = m_val;
          else base_nxt = m_val;
        end
      end
      // double width reduction by the modulus magnitude
      S_RED: begin
        r_nxt   = borrow ? au_a[W-1:0] : au_sum[W-1:0];
        p_nxt   = {p_r[2*W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      S_RFIN: begin
        if (dest_r == DST_T) t_nxt = r_val;
        else base_nxt = r_val;
      end
      // restoring division, one quotient bit a cycle
      S_DIV: begin
        r_nxt          = borrow ? au_a[W-1:0] : au_sum[W-1:0];
        p_nxt[W-1:0]   = {p_r[W-2:0], !borrow};
        cnt_nxt        = cnt_r - 1'b1;
      end
      S_DFIN: begin
        ov_nxt   = 1'b1;
        ores_nxt = sx_f(q_val);
        orem_nxt = sx_f(asgn_r ? (ZERO_W - r_r) : r_r);
        ost_nxt  = (!neg_r && p_r[W-1]) ? STAT_OVF : STAT_OK;
      end
      // power loop: multiply into t on a set exponent bit
      S_STEP: begin
        if (e_r == ZERO_W) begin
          ov_nxt   = 1'b1;
          ores_nxt = sx_f(t_r);
          orem_nxt = '0;
          ost_nxt  = ovf_r ? STAT_OVF : STAT_OK;
        end else if (e_r[0]) begin
          p_nxt    = {ZERO_W, mag_f(base_r)};
          mx_nxt   = mag_f(t_r);
          neg_nxt  = t_r[W-1] ^ base_r[W-1];
          cnt_nxt  = CW'(W - 1);
          dest_nxt = DST_T;
        end
      end
      // power loop: square the base unless this was the top bit
      S_SQ: begin
        e_nxt = {1'b0, e_r[W-1:1]};
        if (e_r[W-1:1] != '0) begin
          p_nxt    = {ZERO_W, mag_f(base_r)};
          mx_nxt   = mag_f(base_r);
          neg_nxt  = 1'b0;
          cnt_nxt  = CW'(W - 1);
          dest_nxt = DST_B;
        end
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
    func_r <= func_nxt;
    p_r    <= p_nxt;
    r_r    <= r_nxt;
    mx_r   <= mx_nxt;
    m_r    <= m_nxt;
    t_r    <= t_nxt;
    base_r <= base_nxt;
    e_r    <= e_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    asgn_r <= asgn_nxt;
    ovf_r  <= ovf_nxt;
    ores_r <= ores_nxt;
    orem_r <= orem_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_valid     = ov_r;
  assign out_result    = ores_r;
  assign out_remainder = orem_r;
  assign out_status    = ost_r;

endmodule
